// ===== rtl/rsc_pkg.sv =====
// Shared types and constants for the rowing stroke classifier.
// Depends on nothing; every other file imports it.
package rsc_pkg;

	// Depth of the queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Scale for the stroke rate: tenths of strokes per minute in milliseconds.
	localparam logic [19:0] RATE_SCALE = 20'd600000;

	// Kind of a queued item.
	typedef enum logic {
		OP_PIN  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_TOP_LEAVE  = 3'd0,
		REG_TOP_ENTER  = 3'd1,
		REG_BOTTOM     = 3'd2,
		REG_MICRO_LIM  = 3'd3,
		REG_SHORT_LIM  = 3'd4,
		REG_MIN_GAP    = 3'd5,
		REG_IDLE_LIM   = 3'd6,
		REG_SESS_LIM   = 3'd7
	} reg_idx_t;

	// Stroke machine phase.
	typedef enum logic [1:0] {
		PH_TOP  = 2'd0,
		PH_DOWN = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic        pin_a;
		logic        pin_b;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic [1:0]         phase;
		logic [31:0]        full_count;
		logic [31:0]        short_count;
		logic [31:0]        micro_count;
		logic [31:0]        valid_travel;
		logic [31:0]        short_travel;
		logic [31:0]        micro_travel;
		logic [31:0]        rate_tenths;
		logic [31:0]        active_ms;
		logic               in_session;
		logic               session_ended;
	} out_item_t;

	// Item as it travels through the queue, already classified.
	typedef struct packed {
		op_t         op;
		logic [1:0]  pins;
		logic [31:0] now_ms;
	} queue_item_t;

	// Configuration registers as seen by the back end.
	typedef struct packed {
		logic signed [31:0] top_leave_level;
		logic signed [31:0] top_enter_level;
		logic signed [31:0] bottom_level;
		logic [30:0]        micro_travel_limit;
		logic [30:0]        short_travel_limit;
		logic [31:0]        min_stroke_interval_ms;
		logic [31:0]        idle_limit_ms;
		logic [31:0]        session_limit_ms;
	} cfg_t;

	// Quadrature step for {previous pins, current pins}: +1, -1 or 0.
	function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
		logic signed [1:0] d;
		unique case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/rsc_front.sv =====
// Front end: accepts request beats, classifies them and queues them in order.
// Depends on rsc_pkg.
module rsc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rsc_pkg::in_item_t    req,
	output logic                 q_valid,
	input  logic                 q_ready,
	output rsc_pkg::queue_item_t q_item
);
	import rsc_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	queue_item_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	queue_item_t    entry;
	logic           push;
	logic           pop;

	// Classify the incoming beat.
	always_comb begin
		entry.op     = req.req_type ? OP_TICK : OP_PIN;
		entry.pins   = {req.pin_a, req.pin_b};
		entry.now_ms = req.now_ms;
	end

	assign req_ready = (count_q != CW'(QUEUE_DEPTH));
	assign push      = req_valid && req_ready;
	assign q_valid   = (count_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rsc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on rsc_pkg only by convention; no shared types are needed.
module rsc_div #(
	parameter int unsigned NUM_W = 23,
	parameter int unsigned DEN_W = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import rsc_pkg::*;

	localparam int unsigned IW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [IW-1:0]    iter_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// One shift and trial subtract per cycle.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
			done   <= 1'b0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IW'(NUM_W);
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], fits};
				iter_q <= iter_q - 1'b1;
				if (iter_q == IW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/rsc_back.sv =====
// Back end: encoder decode, stroke machine, activity timers, stamp ring and rate.
// Depends on rsc_pkg; drives the serial divider.
module rsc_back #(
	parameter int unsigned RING_DEPTH     = 8,
	parameter int unsigned RATE_INTERVALS = 5,
	parameter int unsigned NW             = 3,
	parameter int unsigned NUM_W          = 23,
	parameter int unsigned SUM_W          = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  rsc_pkg::queue_item_t q_item,
	input  rsc_pkg::cfg_t        cfg,
	output logic                 div_start,
	output logic [NUM_W-1:0]     div_num,
	output logic [SUM_W-1:0]     div_den,
	input  logic                 div_done,
	input  logic [NUM_W-1:0]     div_quot,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsc_pkg::out_item_t   rsp
);
	import rsc_pkg::*;

	localparam int unsigned PW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RATE_INTERVALS + 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t             state_q;

	// Architectural state.
	logic [1:0]         last_pins_q;
	logic signed [31:0] pos_q;
	logic               moved_q;
	phase_t             phase_q;
	logic signed [31:0] low_q;
	logic signed [31:0] high_q;
	logic               session_q;
	logic               moving_q;
	logic [31:0]        last_move_q;
	logic [31:0]        move_start_q;
	logic [31:0]        active_q;
	logic [31:0]        last_valid_q;
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [PW-1:0]      ring_ptr_q;
	logic [31:0]        vcount_q, scount_q, mcount_q;
	logic [31:0]        vtravel_q, stravel_q, mtravel_q;

	// Per-tick working registers.
	logic [31:0]        now_q;
	logic               ended_q;
	logic [31:0]        act_q;
	logic [31:0]        rate_q;
	logic [PW-1:0]      rd_addr_q;
	logic [CW-1:0]      rcnt_q;
	logic [31:0]        rd_data_q;
	logic               rd_vld_q;
	logic [31:0]        prev_data_q;
	logic               prev_vld_q;
	logic [SUM_W-1:0]   sum_q;
	logic [NW-1:0]      n_q;
	logic               rsp_valid_q;
	out_item_t          rsp_q;

	logic [31:0]        ring_mem [RING_DEPTH];

	// Tick evaluation signals.
	logic               pop;
	logic               is_tick;
	logic [31:0]        t_now;
	logic [31:0]        t_lm, t_mst, t_el, t_at;
	logic               t_son, t_mov0, t_idle_x, t_sess_x;
	logic signed [31:0] t_lo, t_hi;
	logic [31:0]        t_travel;
	logic               t_deep, t_back;
	logic               t_micro, t_short, t_gap_ok;
	phase_t             t_phase;
	logic               inc_v, inc_s, inc_m;
	logic signed [1:0]  p_step;
	logic               rd_en;
	logic               load_out;

	assign q_ready   = (state_q == ST_IDLE);
	assign pop       = q_valid && q_ready;
	assign is_tick   = (q_item.op == OP_TICK);
	assign t_now     = q_item.now_ms;
	assign p_step    = quad_step({last_pins_q, q_item.pins});
	assign rd_en     = (state_q == ST_RATE) && (rcnt_q <= CW'(RATE_INTERVALS));
	assign load_out  = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign div_start = (state_q == ST_DIVGO) && (n_q != '0) && (sum_q != '0);
	assign div_num   = NUM_W'(NUM_W'(RATE_SCALE) * NUM_W'(n_q));
	assign div_den   = sum_q;

	// Activity timers and stroke machine for one tick.
	always_comb begin
		t_lm     = moved_q ? t_now : last_move_q;
		t_son    = session_q || moved_q;
		t_mov0   = moving_q || moved_q;
		t_mst    = (moved_q && !moving_q) ? t_now : move_start_q;
		t_el     = t_now - t_lm;
		t_idle_x = t_mov0 && (t_el > cfg.idle_limit_ms);
		t_sess_x = t_son && (t_el > cfg.session_limit_ms);
		t_at     = active_q + ((t_mov0 && (t_idle_x || t_sess_x)) ? (t_lm - t_mst) : 32'd0);

		t_lo     = (pos_q < low_q) ? pos_q : low_q;
		t_hi     = (pos_q > high_q) ? pos_q : high_q;
		t_travel = 32'(t_hi - t_lo);
		t_micro  = (t_travel <= {1'b0, cfg.micro_travel_limit});
		t_short  = (t_travel <= {1'b0, cfg.short_travel_limit});
		t_deep   = (t_lo <= cfg.bottom_level);
		t_back   = (pos_q >= cfg.top_enter_level);
		t_gap_ok = ((t_now - last_valid_q) >= cfg.min_stroke_interval_ms);

		t_phase = phase_q;
		inc_v   = 1'b0;
		inc_s   = 1'b0;
		inc_m   = 1'b0;
		unique case (phase_q)
			PH_TOP: begin
				t_lo = pos_q;
				t_hi = pos_q;
				if (pos_q <= cfg.top_leave_level) begin
					t_phase = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (t_deep) begin
					t_phase = PH_WAIT;
				end else if (t_back) begin
					inc_m   = t_micro;
					inc_s   = !t_micro && t_short;
					t_phase = PH_TOP;
				end
			end
			PH_WAIT: begin
				if (t_back) begin
					inc_v   = t_gap_ok;
					inc_m   = !t_gap_ok && t_micro;
					inc_s   = !t_gap_ok && !t_micro;
					t_phase = PH_TOP;
				end
			end
			default: begin
				t_phase = phase_q;
			end
		endcase
	end

	// Stamp memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (pop && is_tick && inc_v) begin
			ring_mem[ring_ptr_q] <= t_now;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr_q];
		end
	end

	// Sequencer with all state but the stamp memory and its read register, and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_pins_q  <= '0;
			pos_q        <= '0;
			moved_q      <= 1'b0;
			phase_q      <= PH_TOP;
			low_q        <= '0;
			high_q       <= '0;
			session_q    <= 1'b0;
			moving_q     <= 1'b0;
			last_move_q  <= '0;
			move_start_q <= '0;
			active_q     <= '0;
			last_valid_q <= '0;
			ring_vld_q   <= '0;
			ring_ptr_q   <= '0;
			vcount_q     <= '0;
			scount_q     <= '0;
			mcount_q     <= '0;
			vtravel_q    <= '0;
			stravel_q    <= '0;
			mtravel_q    <= '0;
			now_q        <= '0;
			ended_q      <= 1'b0;
			act_q        <= '0;
			rate_q       <= '0;
			rd_addr_q    <= '0;
			rcnt_q       <= '0;
			rd_vld_q     <= 1'b0;
			prev_data_q  <= '0;
			prev_vld_q   <= 1'b0;
			sum_q        <= '0;
			n_q          <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !load_out) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !is_tick) begin
						// Pin sample: quadrature decode.
						if (p_step != 2'sd0) begin
							pos_q   <= pos_q + 32'(p_step);
							moved_q <= 1'b1;
						end
						last_pins_q <= q_item.pins;
					end else if (pop) begin
						moved_q      <= 1'b0;
						last_move_q  <= t_lm;
						move_start_q <= t_mst;
						active_q     <= t_at;
						moving_q     <= t_mov0 && !t_idle_x && !t_sess_x;
						session_q    <= t_son && !t_sess_x;
						ended_q      <= t_sess_x;
						low_q        <= t_lo;
						high_q       <= t_hi;
						phase_q      <= t_phase;
						now_q        <= t_now;
						if (inc_v) begin
							vcount_q     <= vcount_q + 1'b1;
							vtravel_q    <= vtravel_q + t_travel;
							last_valid_q <= t_now;
							ring_vld_q[ring_ptr_q] <= 1'b1;
							ring_ptr_q   <= (ring_ptr_q == PW'(RING_DEPTH - 1)) ?
								'0 : ring_ptr_q + 1'b1;
							rd_addr_q    <= ring_ptr_q;
						end else begin
							rd_addr_q    <= (ring_ptr_q == '0) ?
								PW'(RING_DEPTH - 1) : ring_ptr_q - 1'b1;
						end
						if (inc_s) begin
							scount_q  <= scount_q + 1'b1;
							stravel_q <= stravel_q + t_travel;
						end
						if (inc_m) begin
							mcount_q  <= mcount_q + 1'b1;
							mtravel_q <= mtravel_q + t_travel;
						end
						rcnt_q  <= '0;
						sum_q   <= '0;
						n_q     <= '0;
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					// Walk the ring from newest stamp back, one entry a cycle.
					if (rd_en) begin
						rd_vld_q  <= ring_vld_q[rd_addr_q];
						rd_addr_q <= (rd_addr_q == '0) ? PW'(RING_DEPTH - 1) : rd_addr_q - 1'b1;
					end
					if (rcnt_q >= CW'(2)) begin
						if (prev_vld_q && rd_vld_q && (prev_data_q > rd_data_q)) begin
							sum_q <= sum_q + SUM_W'(prev_data_q - rd_data_q);
							n_q   <= n_q + 1'b1;
						end
					end
					if (rcnt_q >= CW'(1)) begin
						prev_data_q <= rd_data_q;
						prev_vld_q  <= rd_vld_q;
					end
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == CW'(RATE_INTERVALS + 1)) begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					act_q  <= active_q + (moving_q ? (now_q - move_start_q) : 32'd0);
					rate_q <= '0;
					state_q <= div_start ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) begin
						rate_q  <= 32'(div_quot);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.position      <= pos_q;
						rsp_q.phase         <= phase_q;
						rsp_q.full_count    <= vcount_q;
						rsp_q.short_count   <= scount_q;
						rsp_q.micro_count   <= mcount_q;
						rsp_q.valid_travel  <= vtravel_q;
						rsp_q.short_travel  <= stravel_q;
						rsp_q.micro_travel  <= mtravel_q;
						rsp_q.rate_tenths   <= rate_q;
						rsp_q.active_ms     <= act_q;
						rsp_q.in_session    <= session_q;
						rsp_q.session_ended <= ended_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rowing_stroke_classifier.sv =====
// Rowing stroke classifier top level: configuration registers, front queue, back end, divider.
// A pin sample beat gives no result. A tick beat holds the back end through the ring walk and
// the serial rate divider, or through the ring walk alone when no rate is divided, and then
// until its result beat is loaded. A two-entry queue lets the front keep accepting meanwhile
// until it is full. Reset clears the control and result state, but not the stored queue or
// stamp memory contents, and loads the default configuration.
module rowing_stroke_classifier #(
	parameter int unsigned RING_DEPTH     = 8,
	parameter int unsigned RATE_INTERVALS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rsc_pkg::in_item_t   req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsc_pkg::out_item_t  rsp,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata
);
	import rsc_pkg::*;

	localparam int unsigned NW    = $clog2(RATE_INTERVALS + 1);
	localparam int unsigned NUM_W = 20 + NW;
	localparam int unsigned SUM_W = 32 + NW;

	cfg_t              cfg_q;
	logic              q_valid;
	logic              q_ready;
	queue_item_t       q_item;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [SUM_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  div_quot;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_leave_level        <= -32'sd20;
			cfg_q.top_enter_level        <= -32'sd5;
			cfg_q.bottom_level           <= -32'sd200;
			cfg_q.micro_travel_limit     <= 31'd20;
			cfg_q.short_travel_limit     <= 31'd100;
			cfg_q.min_stroke_interval_ms <= 32'd800;
			cfg_q.idle_limit_ms          <= 32'd2000;
			cfg_q.session_limit_ms       <= 32'd60000;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TOP_LEAVE: cfg_q.top_leave_level        <= cfg_wdata;
				REG_TOP_ENTER: cfg_q.top_enter_level        <= cfg_wdata;
				REG_BOTTOM:    cfg_q.bottom_level           <= cfg_wdata;
				REG_MICRO_LIM: cfg_q.micro_travel_limit     <= cfg_wdata[30:0];
				REG_SHORT_LIM: cfg_q.short_travel_limit     <= cfg_wdata[30:0];
				REG_MIN_GAP:   cfg_q.min_stroke_interval_ms <= cfg_wdata;
				REG_IDLE_LIM:  cfg_q.idle_limit_ms          <= cfg_wdata;
				REG_SESS_LIM:  cfg_q.session_limit_ms       <= cfg_wdata;
				default:       cfg_q.session_limit_ms       <= cfg_q.session_limit_ms;
			endcase
		end
	end

	// Front end with the item queue.
	rsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	// Back end.
	rsc_back #(
		.RING_DEPTH     (RING_DEPTH),
		.RATE_INTERVALS (RATE_INTERVALS),
		.NW             (NW),
		.NUM_W          (NUM_W),
		.SUM_W          (SUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.cfg       (cfg_q),
		.div_start (div_start),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_done  (div_done),
		.div_quot  (div_quot),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Serial divider for the stroke rate.
	rsc_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

endmodule
